[rtl/roc_auc_pkg.sv]
// Package for the ROC AUC trapezoid accumulator: fixed widths, limits,
// state machine types and control structs. No dependencies.
`timescale 1ns / 1ps

package roc_auc_pkg;

	localparam int FRAC_BITS  = 24;
	localparam int COUNT_BITS = 32;
	localparam int RATE_W     = FRAC_BITS + 1;        // rate in [0, 1.0]
	localparam int DEN_W      = COUNT_BITS + 1;       // tp+fn, fp+tn
	localparam int TRY_W      = DEN_W + 1;            // doubled remainder
	localparam int MUL_W      = RATE_W + 1;           // signed diff / rate sum
	localparam int PROD_W     = 2 * MUL_W;
	localparam int SUM_W      = 60;
	localparam int AREA_W     = 25;
	localparam int MAG_W      = SUM_W - FRAC_BITS - 1;
	localparam int QCNT_W     = $clog2(RATE_W);
	localparam int MCNT_W     = $clog2(MUL_W);
	localparam int IN_DATA_W  = 4 * COUNT_BITS;
	localparam int OUT_DATA_W = ((AREA_W + 7) / 8) * 8;

	localparam logic [RATE_W-1:0] ONE_FIX = RATE_W'(1) << FRAC_BITS;
	localparam logic [SUM_W-1:0]  SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0]  SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic [1:0] {
		D_IDLE,
		D_RUN,
		D_DONE
	} div_state_t;

	typedef enum logic [1:0] {
		M_IDLE,
		M_RUN,
		M_ACC,
		M_OUT
	} mul_state_t;

	typedef struct packed {
		logic ready;
		logic step;
		logic handoff;
	} div_ctrl_t;

	typedef struct packed {
		logic step;
		logic acc_en;
		logic out_load;
	} mul_ctrl_t;

endpackage

[rtl/roc_auc_trapezoid_accumulator_core.sv]
// ROC AUC trapezoid accumulator: two bit-serial rate dividers and a
// bit-serial shift-add multiplier feeding a saturating area sum.
// Depends on roc_auc_pkg.
`timescale 1ns / 1ps

// Overlap: the dividers accept an item, then produce its 25 quotient bits one per
//   cycle and hand off, but the handoff waits for the serial multiply of the
//   previous item (shift-add over all 26 multiplier bits, an accumulate, a return
//   to idle), which overlaps the division of the next item.
// Result: the last item of a run goes through the dividers, the multiplier and the
//   accumulate to M_OUT, which loads m_tvalid; a held result delays the next handoff.
// Reset (arst_n low, asynchronous): run state, area sum and output valid
//   clear; the divider state returns to idle, so s_tready is high out of reset.
module roc_auc_trapezoid_accumulator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// true_pos[31:0], false_pos[63:32], true_neg[95:64], false_neg[127:96]
	input  logic [roc_auc_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// area[24:0], zero pad [31:25]
	output logic [roc_auc_pkg::OUT_DATA_W-1:0]  m_tdata
);

	localparam int CB = roc_auc_pkg::COUNT_BITS;
	localparam int RW = roc_auc_pkg::RATE_W;
	localparam int DW = roc_auc_pkg::DEN_W;
	localparam int TW = roc_auc_pkg::TRY_W;
	localparam int MW = roc_auc_pkg::MUL_W;
	localparam int PW = roc_auc_pkg::PROD_W;
	localparam int SW = roc_auc_pkg::SUM_W;
	localparam int AW = roc_auc_pkg::AREA_W;
	localparam int GW = roc_auc_pkg::MAG_W;

	roc_auc_pkg::div_state_t d_state_q, d_state_nxt;
	roc_auc_pkg::mul_state_t m_state_q, m_state_nxt;
	roc_auc_pkg::div_ctrl_t  dctl;
	roc_auc_pkg::mul_ctrl_t  mctl;

	logic                              accept;

	// divider state
	logic [DW-1:0]                     t_den_q, f_den_q;
	logic [DW-1:0]                     t_rem_q, f_rem_q;
	logic [RW-1:0]                     t_quo_q, f_quo_q;
	logic                              t_zero_q, f_zero_q;
	logic                              last_q;
	logic [roc_auc_pkg::QCNT_W-1:0]    qcnt_q;
	logic [DW-1:0]                     t_rem_nxt, f_rem_nxt;
	logic                              t_bit, f_bit;

	// run state
	logic [RW-1:0]                     prev_tpr_q, prev_fpr_q;
	logic                              have_prev_q;
	logic [RW-1:0]                     tpr_fin, fpr_fin;
	logic [MW-1:0]                     dfpr, stpr;

	// multiplier / accumulator
	logic [MW-1:0]                     mcand_q, mplier_q;
	logic [PW-1:0]                     prod_q;
	logic [roc_auc_pkg::MCNT_W-1:0]    mcnt_q;
	logic                              mul_last_q;
	logic [SW-1:0]                     sum_q;
	logic [SW:0]                       sum_ext;
	logic [SW-1:0]                     sum_sat;
	logic [SW-1:0]                     mag;
	logic [GW-1:0]                     mag_sh;
	logic [AW-1:0]                     area_nxt;
	logic [AW-1:0]                     area_q;
	logic                              out_valid_q;

	// one restoring step: first step compares num itself, later ones 2r
	function automatic logic [DW:0] rdiv_step(input logic [DW-1:0] rem,
			input logic [DW-1:0] den, input logic first);
		logic [TW-1:0] try_v;
		logic [TW-1:0] diff_v;
		logic          ge;
		try_v  = first ? {1'b0, rem} : {rem, 1'b0};
		ge     = (try_v >= {1'b0, den});
		diff_v = try_v - {1'b0, den};
		return ge ? {1'b1, diff_v[DW-1:0]} : {1'b0, try_v[DW-1:0]};
	endfunction

	// ---------------- state machines ----------------
	always_comb begin
		d_state_nxt = d_state_q;
		case (d_state_q)
			roc_auc_pkg::D_IDLE: begin
				if (accept) d_state_nxt = roc_auc_pkg::D_RUN;
			end
			roc_auc_pkg::D_RUN: begin
				if (qcnt_q == roc_auc_pkg::QCNT_W'(RW - 1)) d_state_nxt = roc_auc_pkg::D_DONE;
			end
			roc_auc_pkg::D_DONE: begin
				if (m_state_q == roc_auc_pkg::M_IDLE) d_state_nxt = roc_auc_pkg::D_IDLE;
			end
			default: d_state_nxt = roc_auc_pkg::D_IDLE;
		endcase
	end

	always_comb begin
		dctl.ready   = (d_state_q == roc_auc_pkg::D_IDLE);
		dctl.step    = (d_state_q == roc_auc_pkg::D_RUN);
		dctl.handoff = (d_state_q == roc_auc_pkg::D_DONE) && (m_state_q == roc_auc_pkg::M_IDLE);
	end

	always_comb begin
		m_state_nxt = m_state_q;
		case (m_state_q)
			roc_auc_pkg::M_IDLE: begin
				if (dctl.handoff) m_state_nxt = roc_auc_pkg::M_RUN;
			end
			roc_auc_pkg::M_RUN: begin
				if (mcnt_q == roc_auc_pkg::MCNT_W'(MW - 1)) m_state_nxt = roc_auc_pkg::M_ACC;
			end
			roc_auc_pkg::M_ACC: begin
				m_state_nxt = mul_last_q ? roc_auc_pkg::M_OUT : roc_auc_pkg::M_IDLE;
			end
			roc_auc_pkg::M_OUT: begin
				if (mctl.out_load) m_state_nxt = roc_auc_pkg::M_IDLE;
			end
			default: m_state_nxt = roc_auc_pkg::M_IDLE;
		endcase
	end

	always_comb begin
		mctl.step     = (m_state_q == roc_auc_pkg::M_RUN);
		mctl.acc_en   = (m_state_q == roc_auc_pkg::M_ACC);
		mctl.out_load = (m_state_q == roc_auc_pkg::M_OUT) && (!out_valid_q || m_tready);
	end

	assign s_tready = dctl.ready;
	assign accept   = s_tvalid && dctl.ready;

	// ---------------- datapath comb ----------------
	always_comb begin
		logic first;
		first = (qcnt_q == '0);
		{t_bit, t_rem_nxt} = rdiv_step(t_rem_q, t_den_q, first);
		{f_bit, f_rem_nxt} = rdiv_step(f_rem_q, f_den_q, first);
	end

	assign tpr_fin = t_zero_q ? roc_auc_pkg::ONE_FIX : t_quo_q;
	assign fpr_fin = f_zero_q ? '0 : f_quo_q;
	assign dfpr    = have_prev_q ? ({1'b0, fpr_fin} - {1'b0, prev_fpr_q}) : '0;
	assign stpr    = {1'b0, tpr_fin} + {1'b0, prev_tpr_q};

	assign sum_ext = {sum_q[SW-1], sum_q} + {{(SW + 1 - PW){prod_q[PW-1]}}, prod_q};
	always_comb begin
		if (sum_ext[SW] != sum_ext[SW-1])
			sum_sat = sum_ext[SW] ? roc_auc_pkg::SUM_MIN : roc_auc_pkg::SUM_MAX;
		else
			sum_sat = sum_ext[SW-1:0];
	end

	assign mag    = sum_q[SW-1] ? (~sum_q + SW'(1)) : sum_q;
	assign mag_sh = mag[SW-1:roc_auc_pkg::FRAC_BITS+1];
	assign area_nxt = (mag_sh > GW'(roc_auc_pkg::ONE_FIX)) ? AW'(roc_auc_pkg::ONE_FIX)
		: mag_sh[AW-1:0];

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_state_q   <= roc_auc_pkg::D_IDLE;
			m_state_q   <= roc_auc_pkg::M_IDLE;
			qcnt_q      <= '0;
			mcnt_q      <= '0;
			have_prev_q <= 1'b0;
			prev_tpr_q  <= '0;
			prev_fpr_q  <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			d_state_q <= d_state_nxt;
			m_state_q <= m_state_nxt;
			if (accept)
				qcnt_q <= '0;
			else if (dctl.step)
				qcnt_q <= qcnt_q + roc_auc_pkg::QCNT_W'(1);
			if (dctl.handoff) begin
				mcnt_q      <= '0;
				have_prev_q <= !last_q;
				prev_tpr_q  <= last_q ? '0 : tpr_fin;
				prev_fpr_q  <= last_q ? '0 : fpr_fin;
			end else if (mctl.step) begin
				mcnt_q <= mcnt_q + roc_auc_pkg::MCNT_W'(1);
			end
			if (mctl.acc_en)
				sum_q <= sum_sat;
			else if (mctl.out_load)
				sum_q <= '0;
			if (mctl.out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			t_den_q  <= {1'b0, s_tdata[CB-1:0]} + {1'b0, s_tdata[4*CB-1:3*CB]};
			f_den_q  <= {1'b0, s_tdata[2*CB-1:CB]} + {1'b0, s_tdata[3*CB-1:2*CB]};
			t_rem_q  <= {1'b0, s_tdata[CB-1:0]};
			f_rem_q  <= {1'b0, s_tdata[2*CB-1:CB]};
			t_zero_q <= (s_tdata[CB-1:0] == '0) && (s_tdata[4*CB-1:3*CB] == '0);
			f_zero_q <= (s_tdata[2*CB-1:CB] == '0) && (s_tdata[3*CB-1:2*CB] == '0);
			last_q   <= s_tlast;
		end else if (dctl.step) begin
			t_rem_q <= t_rem_nxt;
			f_rem_q <= f_rem_nxt;
			t_quo_q <= {t_quo_q[RW-2:0], t_bit};
			f_quo_q <= {f_quo_q[RW-2:0], f_bit};
		end
		if (dctl.handoff) begin
			mcand_q    <= dfpr;
			mplier_q   <= stpr;
			prod_q     <= '0;
			mul_last_q <= last_q;
		end else if (mctl.step) begin
			// MSB-first shift-add, one multiplier bit per cycle
			prod_q   <= {prod_q[PW-2:0], 1'b0}
				+ (mplier_q[MW-1] ? {{(PW - MW){mcand_q[MW-1]}}, mcand_q} : '0);
			mplier_q <= {mplier_q[MW-2:0], 1'b0};
		end
		if (mctl.out_load)
			area_q <= area_nxt;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(roc_auc_pkg::OUT_DATA_W - AW){1'b0}}, area_q};

	// ---------------- assertions ----------------
	a_area_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[AW-1:0] <= AW'(roc_auc_pkg::ONE_FIX)))
		else $error("area above 1.0");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("divider ready right after accept");

	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(dctl.handoff && last_q) |=> !have_prev_q)
		else $error("run state not cleared on last item");

	a_out_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_state_q == roc_auc_pkg::M_OUT) |-> mul_last_q)
		else $error("result stage entered for a non-last item");

endmodule

[dv/tb_roc_auc_trapezoid_accumulator_core.sv]
// Testbench for roc_auc_trapezoid_accumulator_core: directed, long-loop and random runs of
// thresholds, each checked against a built-in trapezoid area predictor.
// Depends on roc_auc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_roc_auc_trapezoid_accumulator_core;

	typedef logic [roc_auc_pkg::COUNT_BITS-1:0] count_t;
	typedef logic [roc_auc_pkg::RATE_W-1:0]     rate_t;

	localparam longint TWICE_AREA_MAX = (longint'(1) <<< (roc_auc_pkg::SUM_W - 1)) - 1;
	localparam longint TWICE_AREA_MIN = -TWICE_AREA_MAX - 1;
	// corner-to-corner cycles that drive the sum far out, then back to one square
	localparam int CLIMB_CYCLES  = 25;
	localparam int RETURN_CYCLES = 24;

	logic                               clk;
	logic                               arst_n;
	logic                               s_tvalid;
	logic                               s_tready;
	logic [roc_auc_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                               s_tlast;
	logic                               m_tvalid;
	logic                               m_tready;
	logic [roc_auc_pkg::OUT_DATA_W-1:0] m_tdata;

	// area predictor state
	rate_t  last_tpr;
	rate_t  last_fpr;
	longint twice_area;
	bit     have_point;

	logic [roc_auc_pkg::AREA_W-1:0] area_due_q[$];
	int mismatch_count;
	int src_idle_pct;
	int snk_idle_pct;

	roc_auc_trapezoid_accumulator_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 20)
			$display("%0t: mismatch: %s", $time, what);
	endtask

	// floor(num * 2^FRAC_BITS / den), num <= den
	function automatic rate_t rate_of(logic [roc_auc_pkg::DEN_W-1:0] num,
			logic [roc_auc_pkg::DEN_W-1:0] den);
		logic [63:0] scaled;
		scaled = 64'(num) << roc_auc_pkg::FRAC_BITS;
		return rate_t'(scaled / 64'(den));
	endfunction

	function automatic void add_threshold(count_t tp, count_t fp, count_t tn, count_t fn,
			bit last);
		logic [roc_auc_pkg::DEN_W-1:0] pos_total;
		logic [roc_auc_pkg::DEN_W-1:0] neg_total;
		rate_t  tpr;
		rate_t  fpr;
		longint dfpr;
		longint stpr;
		longint tmp;
		longint mag;
		pos_total = roc_auc_pkg::DEN_W'(tp) + roc_auc_pkg::DEN_W'(fn);
		neg_total = roc_auc_pkg::DEN_W'(fp) + roc_auc_pkg::DEN_W'(tn);
		tpr = (pos_total == 0) ? roc_auc_pkg::ONE_FIX
			: rate_of(roc_auc_pkg::DEN_W'(tp), pos_total);
		fpr = (neg_total == 0) ? rate_t'(0) : rate_of(roc_auc_pkg::DEN_W'(fp), neg_total);
		if (have_point) begin
			dfpr = fpr;
			tmp = last_fpr;
			dfpr = dfpr - tmp;
			stpr = tpr;
			tmp = last_tpr;
			stpr = stpr + tmp;
			tmp = twice_area + dfpr * stpr;
			if (tmp > TWICE_AREA_MAX)
				tmp = TWICE_AREA_MAX;
			if (tmp < TWICE_AREA_MIN)
				tmp = TWICE_AREA_MIN;
			twice_area = tmp;
		end
		last_tpr = tpr;
		last_fpr = fpr;
		have_point = 1'b1;
		if (last) begin
			mag = (twice_area < 0) ? -twice_area : twice_area;
			mag = mag >>> (roc_auc_pkg::FRAC_BITS + 1);
			if (mag > roc_auc_pkg::ONE_FIX)
				mag = roc_auc_pkg::ONE_FIX;
			area_due_q.push_back(roc_auc_pkg::AREA_W'(mag));
			last_tpr = '0;
			last_fpr = '0;
			twice_area = 0;
			have_point = 1'b0;
		end
	endfunction

	task automatic send_threshold(count_t tp, count_t fp, count_t tn, count_t fn, bit last);
		int gap;
		@(negedge clk);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {fn, tn, fp, tp};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		add_threshold(tp, fp, tn, fn, last);
	endtask

	// drop valid and hold off until every pending area has come out
	task automatic wait_results_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (area_due_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic count_t any_count();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return count_t'('1) - count_t'($urandom_range(0, 3));
			3, 4: return count_t'($urandom_range(0, 16));
			default: return count_t'($urandom);
		endcase
	endfunction

	function automatic count_t pick_total();
		case ($urandom_range(0, 3))
			0: return count_t'($urandom_range(0, 20));
			1: return count_t'($urandom_range(0, 100000));
			default: return count_t'($urandom);
		endcase
	endfunction

	// threshold whose rates sit exactly at 0 or 1.0, with random counts
	task automatic send_corner(bit fpr_one, bit tpr_one, bit last);
		count_t tp;
		count_t fp;
		count_t tn;
		count_t fn;
		count_t nz;
		nz = any_count();
		if (nz == 0)
			nz = 1;
		tp = tpr_one ? count_t'($urandom) : '0;
		fn = tpr_one ? '0 : nz;
		fp = fpr_one ? nz : '0;
		tn = fpr_one ? '0 : count_t'($urandom);
		send_threshold(tp, fp, tn, fn, last);
	endtask

	// mostly a proper curve (monotone counts, fixed totals), sometimes plain noise
	task automatic send_random_run(int len);
		bit          wellformed;
		bit          falling;
		count_t      pos_total;
		count_t      neg_total;
		count_t      tp;
		count_t      fp;
		logic [63:0] rem;
		logic [63:0] stride;
		wellformed = ($urandom_range(0, 99) < 80);
		falling = $urandom_range(0, 1);
		pos_total = pick_total();
		neg_total = pick_total();
		tp = '0;
		fp = '0;
		for (int i = 0; i < len; i++) begin
			if (!wellformed) begin
				send_threshold(any_count(), any_count(), any_count(), any_count(),
					i == len - 1);
			end else begin
				rem = pos_total - tp;
				stride = (64'($urandom) * rem) >> 31;
				tp = tp + count_t'((stride > rem) ? rem : stride);
				rem = neg_total - fp;
				stride = (64'($urandom) * rem) >> 31;
				fp = fp + count_t'((stride > rem) ? rem : stride);
				if (falling)
					send_threshold(pos_total - tp, neg_total - fp, fp, tp, i == len - 1);
				else
					send_threshold(tp, fp, neg_total - fp, pos_total - tp, i == len - 1);
			end
		end
	endtask

	task automatic test_directed();
		// single-threshold runs give zero area
		send_threshold(count_t'($urandom), count_t'($urandom), count_t'($urandom),
			count_t'($urandom), 1'b1);
		send_threshold('1, '1, '1, '1, 1'b1);
		// empty denominators, then all-max counts
		send_threshold('0, '0, '0, '0, 1'b0);
		send_threshold('1, '1, '1, '1, 1'b1);
		// perfect classifier, both threshold orders: area exactly 1.0
		send_threshold(0, 0, 50, 40, 1'b0);
		send_threshold(40, 0, 50, 0, 1'b0);
		send_threshold(40, 50, 0, 0, 1'b1);
		send_threshold(40, 50, 0, 0, 1'b0);
		send_threshold(40, 0, 50, 0, 1'b0);
		send_threshold(0, 0, 50, 40, 1'b1);
		// curve that loops back adds up to 2.0, output clamps to 1.0
		send_corner(1'b0, 1'b1, 1'b0);
		send_corner(1'b1, 1'b1, 1'b0);
		send_corner(1'b1, 1'b0, 1'b0);
		send_corner(1'b0, 1'b0, 1'b0);
		send_corner(1'b0, 1'b1, 1'b0);
		send_corner(1'b1, 1'b1, 1'b1);
		// truncated rates, carry into the 33-bit denominator
		send_threshold(1, 1, 2, 2, 1'b0);
		send_threshold('1, '1, 1, 1, 1'b0);
		send_threshold(3, 7, 0, 5, 1'b1);
		// empty denominators after a real point
		send_threshold(0, 9, 3, 7, 1'b0);
		send_threshold(0, 0, 0, 0, 1'b1);
	endtask

	// long looping run that drives the sum far from zero, then walks back to
	// one unit square: area lands exactly on 1.0
	task automatic test_long_loop(bit downward);
		for (int k = 0; k < CLIMB_CYCLES + RETURN_CYCLES; k++) begin
			bit up = (k < CLIMB_CYCLES) ^ downward;
			for (int j = 0; j < 4; j++)
				send_corner(j == 1 || j == 2, up ? (j <= 1) : (j >= 2),
					k == CLIMB_CYCLES + RETURN_CYCLES - 1 && j == 3);
		end
	endtask

	task automatic test_pause_until_drained();
		send_random_run($urandom_range(2, 6));
		send_random_run($urandom_range(1, 4));
		wait_results_drained();
		send_random_run($urandom_range(2, 6));
		wait_results_drained();
	endtask

	task automatic test_random_runs(int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 19))
				0: len = $urandom_range(31, 80);
				1, 2, 3, 4, 5: len = $urandom_range(9, 30);
				default: len = $urandom_range(1, 8);
			endcase
			if (len > n_items - sent)
				len = n_items - sent;
			send_random_run(len);
			sent += len;
			if ($urandom_range(0, 99) < 4)
				wait_results_drained();
		end
	endtask

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	always @(posedge clk) begin : area_check
		logic [roc_auc_pkg::AREA_W-1:0] due;
		if (arst_n && m_tvalid && m_tready) begin
			if (area_due_q.size() == 0) begin
				report_mismatch($sformatf("area item 0x%0h with none pending", m_tdata));
			end else begin
				due = area_due_q.pop_front();
				if (m_tdata[roc_auc_pkg::AREA_W-1:0] !== due)
					report_mismatch($sformatf("area 0x%0h, predicted 0x%0h",
						m_tdata[roc_auc_pkg::AREA_W-1:0], due));
				if (m_tdata[roc_auc_pkg::OUT_DATA_W-1:roc_auc_pkg::AREA_W] !== '0)
					report_mismatch($sformatf("pad bits 0x%0h not zero",
						m_tdata[roc_auc_pkg::OUT_DATA_W-1:roc_auc_pkg::AREA_W]));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		last_tpr = '0;
		last_fpr = '0;
		twice_area = 0;
		have_point = 1'b0;
		mismatch_count = 0;
		src_idle_pct = 14;
		snk_idle_pct = 57;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_runs(350);

		src_idle_pct = 57;
		snk_idle_pct = 14;
		test_pause_until_drained();
		test_long_loop(1'b0);
		test_random_runs(350);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_long_loop(1'b1);
		test_random_runs(330);

		wait_results_drained();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[roc_auc_trapezoid_accumulator_core.f]
rtl/roc_auc_pkg.sv
rtl/roc_auc_trapezoid_accumulator_core.sv
dv/tb_roc_auc_trapezoid_accumulator_core.sv
